FILE: rtl/wlps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlps_pkg
// Shared types and constants of the wildcard line pattern search core.
// ----------------------------------------------------------------------------
package wlps_pkg;

  localparam int FIELD_W    = 31;
  localparam int LEN_CFG_W  = 9;
  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 8;

  localparam logic [BYTE_W-1:0]  WILDCARD_BYTE = 8'd63;
  localparam logic [FIELD_W-1:0] LINE_SAT      = 31'd1073741825;
  localparam logic [FIELD_W-1:0] COLUMN_SAT    = 31'd1073741824;

  typedef enum logic [1:0] {
    KIND_MASK = 2'd0,
    KIND_TEXT = 2'd1,
    KIND_EOL  = 2'd2
  } kind_t;

  // Broadcast from the control logic to every cell of the row
  typedef struct packed {
    logic               text;
    logic               clear;
    logic               wr;
    logic [INDEX_W-1:0] wr_idx;
    logic [BYTE_W-1:0]  data;
  } bcast_t;

  typedef struct packed {
    logic [FIELD_W-1:0] line_number;
    logic [FIELD_W-1:0] column;
    logic [FIELD_W-1:0] lines_matched;
  } result_t;

endpackage

FILE: rtl/wlps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlps_cell
// One mask position: holds its mask byte and its partial-match bit.
// ----------------------------------------------------------------------------
module wlps_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  wlps_pkg::bcast_t bcast,
  input  logic            prev,
  output logic            match_q,
  output logic            match_next
);

  logic [wlps_pkg::BYTE_W-1:0] mask_byte;
  logic                        accepts;

  assign accepts = (mask_byte == wlps_pkg::WILDCARD_BYTE) || (mask_byte == bcast.data);

  always_comb begin
    if (bcast.text) begin
      match_next = prev & accepts;
    end else if (bcast.clear) begin
      match_next = 1'b0;
    end else begin
      match_next = match_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (bcast.wr && (int'(bcast.wr_idx) == CELL_IDX)) begin
      mask_byte <= bcast.data;
    end
  end

endmodule

FILE: rtl/wlps_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlps_chain
// Row of mask cells; each cell passes its partial-match bit to the next one.
// ----------------------------------------------------------------------------
module wlps_chain #(
  parameter int MASK_MAX = 256,
  parameter int IDX_W    = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  wlps_pkg::bcast_t bcast,
  input  logic [IDX_W-1:0] sel,
  output logic             hit
);

  logic [MASK_MAX-1:0] bits_q;
  logic [MASK_MAX-1:0] bits_next;

  for (genvar k = 0; k < MASK_MAX; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = bits_q[k-1];
    end
    wlps_cell #(.CELL_IDX(k)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .bcast      (bcast),
      .prev       (prev),
      .match_q    (bits_q[k]),
      .match_next (bits_next[k])
    );
  end

  // tap the updated bit of the last mask position in use
  assign hit = bits_next[sel];

endmodule

FILE: rtl/wlps_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlps_out_buf
// Output register with one skid entry behind it.
// ----------------------------------------------------------------------------
module wlps_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wlps_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output wlps_pkg::result_t out_data
);

  logic              main_valid;
  logic              skid_valid;
  wlps_pkg::result_t skid_data;
  logic              pop;

  assign pop       = main_valid && !out_stall;
  assign out_valid = main_valid;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!main_valid || pop) begin
        if (skid_valid) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          main_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed while skid entry occupied");

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry holds data with output register empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(push) && $past(main_valid) && $past(out_stall))
    else $error("skid entry filled without a stalled push");

endmodule

FILE: rtl/wildcard_line_pattern_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_line_pattern_search_core
// Shift-and search of a wildcard mask over text lines; reports the first
// match of each line with its line, start column and matched-line count.
// ----------------------------------------------------------------------------
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   config   | cfg_write           | cfg_data (mask length)
//   input    | in_valid / in_stall | kind, mask_index, byte_value
//   output   | out_valid/out_stall | line_number, column, lines_matched
//
// One transaction per cycle while in_stall is low: every cell of the mask
// row updates its partial-match bit in the cycle the transaction is
// accepted, and a result is registered at that same edge.
// Reset clears partial-match bits and counters; mask bytes stay undefined
// until written. in_stall rises only while both output entries are full.
// ----------------------------------------------------------------------------
module wildcard_line_pattern_search_core #(
  parameter int MASK_MAX = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [wlps_pkg::LEN_CFG_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     kind,
  input  logic [wlps_pkg::INDEX_W-1:0]   mask_index,
  input  logic [wlps_pkg::BYTE_W-1:0]    byte_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wlps_pkg::FIELD_W-1:0]   line_number,
  output logic [wlps_pkg::FIELD_W-1:0]   column,
  output logic [wlps_pkg::FIELD_W-1:0]   lines_matched
);

  localparam int IDX_W = (MASK_MAX > 1) ? $clog2(MASK_MAX) : 1;
  localparam int LEN_W = ($clog2(MASK_MAX + 1) > wlps_pkg::LEN_CFG_W) ?
                         $clog2(MASK_MAX + 1) : wlps_pkg::LEN_CFG_W;

  logic [wlps_pkg::LEN_CFG_W-1:0] mask_length;
  logic [wlps_pkg::FIELD_W-1:0]   line_counter, line_counter_next;
  logic [wlps_pkg::FIELD_W-1:0]   column_counter, column_counter_next;
  logic [wlps_pkg::FIELD_W-1:0]   match_line_count, match_line_count_next;
  logic                           line_found, line_found_next;

  logic              accept;
  logic [LEN_W-1:0]  len_raw;
  logic [LEN_W-1:0]  len_eff;
  logic [IDX_W-1:0]  sel;
  logic              hit;
  logic              push;
  wlps_pkg::bcast_t  bcast;
  wlps_pkg::result_t push_data;
  wlps_pkg::result_t out_data;
  wlps_pkg::kind_t   kind_code;

  assign accept    = in_valid && !in_stall;
  assign kind_code = wlps_pkg::kind_t'(kind);

  // clamp the configured length into 1..MASK_MAX
  assign len_raw = LEN_W'(mask_length);
  always_comb begin
    if (len_raw == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_raw > LEN_W'(MASK_MAX)) begin
      len_eff = LEN_W'(MASK_MAX);
    end else begin
      len_eff = len_raw;
    end
  end
  assign sel = IDX_W'(len_eff - LEN_W'(1));

  always_comb begin
    bcast.text   = accept && (kind_code == wlps_pkg::KIND_TEXT);
    bcast.clear  = accept && (kind_code == wlps_pkg::KIND_EOL);
    bcast.wr     = accept && (kind_code == wlps_pkg::KIND_MASK);
    bcast.wr_idx = mask_index;
    bcast.data   = byte_value;
  end

  wlps_chain #(.MASK_MAX(MASK_MAX), .IDX_W(IDX_W)) u_chain (
    .clk   (clk),
    .rst   (rst),
    .bcast (bcast),
    .sel   (sel),
    .hit   (hit)
  );

  always_comb begin
    line_counter_next     = line_counter;
    column_counter_next   = column_counter;
    match_line_count_next = match_line_count;
    line_found_next       = line_found;
    push                  = 1'b0;
    if (accept) begin
      case (kind_code)
        wlps_pkg::KIND_TEXT: begin
          if (column_counter < wlps_pkg::COLUMN_SAT) begin
            column_counter_next = column_counter + 31'd1;
          end
          if (!line_found && hit &&
              (column_counter_next >= wlps_pkg::FIELD_W'(len_eff))) begin
            push            = 1'b1;
            line_found_next = 1'b1;
            if (match_line_count < wlps_pkg::LINE_SAT) begin
              match_line_count_next = match_line_count + 31'd1;
            end
          end
        end
        wlps_pkg::KIND_EOL: begin
          if (line_counter < wlps_pkg::LINE_SAT) begin
            line_counter_next = line_counter + 31'd1;
          end
          column_counter_next = '0;
          line_found_next     = 1'b0;
        end
        default: begin
          // mask writes go straight to the cells; other codes are dropped
        end
      endcase
    end
  end

  always_comb begin
    push_data.line_number   = line_counter;
    push_data.column        = column_counter_next - wlps_pkg::FIELD_W'(len_eff) + 31'd1;
    push_data.lines_matched = match_line_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_length      <= wlps_pkg::LEN_CFG_W'(1);
      line_counter     <= 31'd1;
      column_counter   <= '0;
      match_line_count <= '0;
      line_found       <= 1'b0;
    end else begin
      if (cfg_write) begin
        mask_length <= cfg_data;
      end
      line_counter     <= line_counter_next;
      column_counter   <= column_counter_next;
      match_line_count <= match_line_count_next;
      line_found       <= line_found_next;
    end
  end

  wlps_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign line_number   = out_data.line_number;
  assign column        = out_data.column;
  assign lines_matched = out_data.lines_matched;

endmodule

FILE: verif/wlps_match_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlps_match_checker
// Watches the input, output and length channels of the search core, predicts
// the first match of each line and compares every result field by field.
// ----------------------------------------------------------------------------
module wlps_match_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [wlps_pkg::LEN_CFG_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     kind,
  input  logic [wlps_pkg::INDEX_W-1:0]   mask_index,
  input  logic [wlps_pkg::BYTE_W-1:0]    byte_value,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [wlps_pkg::FIELD_W-1:0]   line_number,
  input  logic [wlps_pkg::FIELD_W-1:0]   column,
  input  logic [wlps_pkg::FIELD_W-1:0]   lines_matched,
  output int                             failures,
  output int                             pending,
  output int                             results_checked
);

  localparam int ROW_LEN         = 256;
  localparam int MATCH_LEN_LIMIT = 1000;

  logic [wlps_pkg::BYTE_W-1:0]    pattern_mem [ROW_LEN];
  logic [ROW_LEN-1:0]             prefix_hit;
  logic [wlps_pkg::FIELD_W-1:0]   line_no;
  logic [wlps_pkg::FIELD_W-1:0]   col_no;
  logic [wlps_pkg::FIELD_W-1:0]   hit_lines;
  logic                           line_done;
  logic [wlps_pkg::LEN_CFG_W-1:0] len_reg;
  wlps_pkg::result_t              match_q [$];
  wlps_pkg::result_t              want;

  // Advance the search state by one transaction; queue a result on the
  // first complete window of the current line.
  task automatic scan_item(input logic [1:0] k, input logic [wlps_pkg::INDEX_W-1:0] idx,
                           input logic [wlps_pkg::BYTE_W-1:0] b);
    logic [ROW_LEN-1:0]           accepts;
    logic [wlps_pkg::FIELD_W-1:0] eff;
    wlps_pkg::result_t            hit;
    case (k)
      wlps_pkg::KIND_MASK: pattern_mem[idx] = b;
      wlps_pkg::KIND_EOL: begin
        if (line_no < wlps_pkg::LINE_SAT) line_no++;
        col_no     = '0;
        line_done  = 1'b0;
        prefix_hit = '0;
      end
      wlps_pkg::KIND_TEXT: begin
        if (col_no < wlps_pkg::COLUMN_SAT) col_no++;
        for (int j = 0; j < ROW_LEN; j++)
          accepts[j] = (pattern_mem[j] == wlps_pkg::WILDCARD_BYTE) || (pattern_mem[j] == b);
        prefix_hit = {prefix_hit[ROW_LEN-2:0], 1'b1} & accepts;
        if (len_reg == '0) eff = wlps_pkg::FIELD_W'(1);
        else if (len_reg > ROW_LEN) eff = wlps_pkg::FIELD_W'(ROW_LEN);
        else eff = wlps_pkg::FIELD_W'(len_reg);
        if (eff <= MATCH_LEN_LIMIT && !line_done && prefix_hit[eff-1] && col_no >= eff) begin
          line_done = 1'b1;
          if (hit_lines < wlps_pkg::LINE_SAT) hit_lines++;
          hit.line_number   = line_no;
          hit.column        = col_no - eff + 31'd1;
          hit.lines_matched = hit_lines;
          match_q = {match_q, hit};
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < ROW_LEN; j++) pattern_mem[j] = '0;
      prefix_hit      = '0;
      line_no         = 31'd1;
      col_no          = '0;
      hit_lines       = '0;
      line_done       = 1'b0;
      len_reg         = 9'd1;
      match_q.delete();
      failures        = 0;
      pending         = 0;
      results_checked = 0;
    end else begin
      if (cfg_write) len_reg = cfg_data;
      if (in_valid && !in_stall) scan_item(kind, mask_index, byte_value);
      if (out_valid && !out_stall) begin
        results_checked++;
        if (match_q.size() == 0) begin
          failures++;
          $error("unexpected result: line_number %0d, column %0d, lines_matched %0d",
                 line_number, column, lines_matched);
        end else begin
          want = match_q.pop_front();
          if (line_number !== want.line_number) begin
            failures++;
            $error("line_number: expected %0d, got %0d", want.line_number, line_number);
          end
          if (column !== want.column) begin
            failures++;
            $error("column: expected %0d, got %0d", want.column, column);
          end
          if (lines_matched !== want.lines_matched) begin
            failures++;
            $error("lines_matched: expected %0d, got %0d", want.lines_matched, lines_matched);
          end
        end
      end
      pending = match_q.size();
    end
  end

endmodule

FILE: verif/wildcard_line_pattern_search_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_line_pattern_search_core_test
// Drives mask loads, text lines and length settings into the search core
// with random idle and stall, including a long output hold-off, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module wildcard_line_pattern_search_core_test;

  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam int RANDOM_ITEMS  = 1450;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_LEN      = 300;
  localparam int RX_CALM_START = 1000;
  localparam int RX_CALM_END   = 1500;
  localparam int TX_CALM_START = 1400;
  localparam int TX_CALM_END   = 1700;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_write;
  logic [wlps_pkg::LEN_CFG_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic [1:0]                     kind;
  logic [wlps_pkg::INDEX_W-1:0]   mask_index;
  logic [wlps_pkg::BYTE_W-1:0]    byte_value;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [wlps_pkg::FIELD_W-1:0]   line_number;
  logic [wlps_pkg::FIELD_W-1:0]   column;
  logic [wlps_pkg::FIELD_W-1:0]   lines_matched;

  int failures;
  int pending;
  int results_checked;
  int cycle_cnt      = 0;
  int stall_cycles   = 0;
  int accepted_items = 0;
  int settings_used  = 0;
  int eff_len        = 1;
  int hold_left      = 0;
  bit hold_req       = 1'b0;
  bit hold_taken     = 1'b0;

  logic [wlps_pkg::BYTE_W-1:0] mask_image [256];
  logic [wlps_pkg::BYTE_W-1:0] line_buf [300];

  wildcard_line_pattern_search_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .mask_index   (mask_index),
    .byte_value   (byte_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_number  (line_number),
    .column       (column),
    .lines_matched(lines_matched)
  );

  wlps_match_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .mask_index     (mask_index),
    .byte_value     (byte_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .line_number    (line_number),
    .column         (column),
    .lines_matched  (lines_matched),
    .failures       (failures),
    .pending        (pending),
    .results_checked(results_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (in_stall === 1'b1) stall_cycles++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: on request hold off for a long stretch so the core backs up,
  // stay calm for another stretch, stall at random otherwise.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_left  = HOLD_LEN - 1;
      hold_taken = 1'b1;
    end else if (cycle_cnt >= RX_CALM_START && cycle_cnt < RX_CALM_END)
      out_stall <= 1'b0;
    else
      out_stall <= ($urandom_range(99) < 12);
  end

  function automatic logic [wlps_pkg::BYTE_W-1:0] pick_char();
    if ($urandom_range(99) < 10) return wlps_pkg::BYTE_W'($urandom_range(255));
    return wlps_pkg::BYTE_W'("a" + $urandom_range(3));
  endfunction

  // Offer one transaction and hold it until accepted; returns at a falling
  // edge with in_valid still high.
  task automatic send_item(input logic [1:0] k, input logic [wlps_pkg::INDEX_W-1:0] idx,
                           input logic [wlps_pkg::BYTE_W-1:0] b);
    bit calm;
    calm = accepted_items >= TX_CALM_START && accepted_items < TX_CALM_END;
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    mask_index <= idx;
    byte_value <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k != KIND_NONE) accepted_items++;
    if (k == wlps_pkg::KIND_MASK) mask_image[idx] = b;
    @(negedge clk);
  endtask

  // Drain every pending result, let the core settle, then write the length.
  task automatic set_length(input logic [wlps_pkg::LEN_CFG_W-1:0] v);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (v == 0) eff_len = 1;
    else if (v > 256) eff_len = 256;
    else eff_len = int'(v);
    settings_used++;
  endtask

  task automatic write_mask(input int len);
    for (int j = 0; j < len; j++)
      send_item(wlps_pkg::KIND_MASK, wlps_pkg::INDEX_W'(j),
                ($urandom_range(99) < 30) ? wlps_pkg::WILDCARD_BYTE : pick_char());
  endtask

  // One text line, optionally carrying a copy of the mask, with occasional
  // ignored kinds and mask rewrites mixed in.
  task automatic send_line(input int len, input bit embed, input bit with_eol);
    int p;
    for (int j = 0; j < len; j++) line_buf[j] = pick_char();
    if (embed && len >= eff_len) begin
      p = $urandom_range(len - eff_len);
      for (int j = 0; j < eff_len; j++)
        line_buf[p+j] = (mask_image[j] == wlps_pkg::WILDCARD_BYTE) ? pick_char() : mask_image[j];
    end
    for (int j = 0; j < len; j++) begin
      case ($urandom_range(99))
        0: send_item(KIND_NONE, wlps_pkg::INDEX_W'($urandom_range(255)),
                     wlps_pkg::BYTE_W'($urandom_range(255)));
        1: send_item(wlps_pkg::KIND_MASK, wlps_pkg::INDEX_W'($urandom_range(255)),
                     pick_char());
        default: ;
      endcase
      send_item(wlps_pkg::KIND_TEXT, wlps_pkg::INDEX_W'($urandom_range(255)), line_buf[j]);
    end
    if (with_eol)
      send_item(wlps_pkg::KIND_EOL, wlps_pkg::INDEX_W'($urandom_range(255)),
                wlps_pkg::BYTE_W'($urandom_range(255)));
  endtask

  initial begin
    int cfg_v;
    int nlines;
    int r;
    int base;
    int phase;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    kind       = '0;
    mask_index = '0;
    byte_value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill the whole mask store so no search ever reads an unwritten entry
    for (int j = 0; j < 256; j++)
      send_item(wlps_pkg::KIND_MASK, wlps_pkg::INDEX_W'(j),
                wlps_pkg::BYTE_W'($urandom_range(255)));

    // Single wildcard: first byte matches, the second hit in the line drops
    set_length(9'd1);
    send_item(wlps_pkg::KIND_MASK, 8'd0, wlps_pkg::WILDCARD_BYTE);
    send_item(wlps_pkg::KIND_TEXT, 8'd0, 8'h00);
    send_item(wlps_pkg::KIND_TEXT, 8'hFF, 8'hFF);
    send_item(wlps_pkg::KIND_EOL, 8'd0, 8'd0);
    send_item(wlps_pkg::KIND_MASK, 8'd0, 8'hFF);
    send_item(wlps_pkg::KIND_TEXT, 8'd0, 8'h00);
    send_item(wlps_pkg::KIND_TEXT, 8'd0, 8'hFF);
    send_item(wlps_pkg::KIND_EOL, 8'hFF, 8'hFF);
    send_item(KIND_NONE, 8'hFF, 8'hFF);
    send_item(wlps_pkg::KIND_EOL, 8'd0, 8'd0);
    // Hold the receiver and keep offering one-byte matching lines so both
    // output entries fill and the input backs up
    hold_req = 1'b1;
    for (int j = 0; j < 30; j++) begin
      send_item(wlps_pkg::KIND_TEXT, 8'd0, 8'hFF);
      send_item(wlps_pkg::KIND_EOL, 8'd0, 8'd0);
    end
    // Three-byte mask with a wildcard in the middle; a short line first
    set_length(9'd3);
    send_item(wlps_pkg::KIND_MASK, 8'd0, "a");
    send_item(wlps_pkg::KIND_MASK, 8'd1, wlps_pkg::WILDCARD_BYTE);
    send_item(wlps_pkg::KIND_MASK, 8'd2, "c");
    send_item(wlps_pkg::KIND_TEXT, 8'd0, "a");
    send_item(wlps_pkg::KIND_TEXT, 8'd0, "b");
    send_item(wlps_pkg::KIND_EOL, 8'd0, 8'd0);
    send_item(wlps_pkg::KIND_TEXT, 8'd0, "x");
    send_item(wlps_pkg::KIND_TEXT, 8'd0, "a");
    send_item(wlps_pkg::KIND_TEXT, 8'd0, "z");
    send_item(wlps_pkg::KIND_TEXT, 8'd0, "c");
    send_item(wlps_pkg::KIND_EOL, 8'd0, 8'd0);
    send_item(wlps_pkg::KIND_MASK, 8'hFF, 8'h00);

    base  = accepted_items;
    phase = 0;
    while (accepted_items - base < RANDOM_ITEMS) begin
      case (phase)
        1: cfg_v = 511;
        2: cfg_v = 256;
        3: cfg_v = 0;
        default: begin
          r = $urandom_range(99);
          if (r < 70) cfg_v = $urandom_range(1, 6);
          else if (r < 90) cfg_v = $urandom_range(7, 20);
          else cfg_v = $urandom_range(21, 64);
        end
      endcase
      set_length(wlps_pkg::LEN_CFG_W'(cfg_v));
      // Reuse the full-length mask loaded in the previous phase
      if (phase != 2) write_mask(eff_len);
      if (eff_len == 256) begin
        send_line(eff_len + $urandom_range(4), 1'b1, 1'b1);
      end else begin
        nlines = $urandom_range(2, 6);
        for (int n = 0; n < nlines; n++)
          send_line($urandom_range(eff_len + 10, (eff_len > 2) ? eff_len - 2 : 0),
                    $urandom_range(99) < 70,
                    (n < nlines - 1) || ($urandom_range(99) < 90));
      end
      phase++;
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d transactions over %0d length settings, %0d matches checked.",
             accepted_items, settings_used, results_checked);
    $display("Input backpressure seen for %0d cycles during %0d cycles of output hold-off.",
             stall_cycles, HOLD_LEN);
    if (failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/wlps_pkg.sv
rtl/wlps_cell.sv
rtl/wlps_chain.sv
rtl/wlps_out_buf.sv
rtl/wildcard_line_pattern_search_core.sv
verif/wlps_match_checker.sv
verif/wildcard_line_pattern_search_core_test.sv
